// ===== hw/rtl/cacd_pkg.sv =====
`timescale 1ns / 1ps

package cacd_pkg;

    // Sign ring geometry (fixed, power of two so offsets wrap by truncation)
    localparam int RING_AW    = 8;
    localparam int RING_DEPTH = 1 << RING_AW;

    // Schmitt clipper thresholds
    localparam logic signed [15:0] CLIP_HIGH = 16'sd100;
    localparam logic signed [15:0] CLIP_LOW  = -16'sd100;

    // Q15 fraction scaling
    localparam int Q15_SHIFT = 15;

    // Status codes
    localparam logic [1:0] ST_WARM  = 2'd0;
    localparam logic [1:0] ST_NODET = 2'd1;
    localparam logic [1:0] ST_DET   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_LAG_MIN     = 3'd0;
    localparam logic [2:0] REG_LAG_MAX     = 3'd1;
    localparam logic [2:0] REG_GUARD_A     = 3'd2;
    localparam logic [2:0] REG_GUARD_B     = 3'd3;
    localparam logic [2:0] REG_WINDOW_LEN  = 3'd4;
    localparam logic [2:0] REG_DETECT_FRAC = 3'd5;
    localparam logic [2:0] REG_MARGIN_FRAC = 3'd6;

    typedef logic signed [1:0]  t_sign;
    typedef logic signed [11:0] t_acc;

    typedef struct packed {
        logic [7:0]  lag_min;
        logic [7:0]  lag_max;
        logic [7:0]  guard_lag_a;
        logic [7:0]  guard_lag_b;
        logic [7:0]  window_len;
        logic [14:0] detect_frac;
        logic [14:0] margin_frac;
    } t_cfg;

endpackage

// ===== hw/rtl/cacd_ram.sv =====
`timescale 1ns / 1ps

module cacd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/cacd_decide.sv =====
`timescale 1ns / 1ps

module cacd_decide (
    input  logic                i_clk,
    input  logic                i_load,
    input  cacd_pkg::t_cfg      i_cfg,
    input  logic                i_warm,
    input  cacd_pkg::t_acc      i_best,
    input  cacd_pkg::t_acc      i_guard_a,
    input  cacd_pkg::t_acc      i_guard_b,
    output logic [1:0]          o_status,
    output logic [9:0]          o_band_peak,
    output logic signed [10:0]  o_guard_peak
);
    import cacd_pkg::*;

    logic [22:0]        thr_prod;
    logic [22:0]        margin_prod;
    logic [7:0]         r_thr;
    logic [7:0]         r_margin;
    t_acc               gmax;
    logic signed [12:0] guard_need;
    logic               det;

    // Window-scaled threshold and margin, registered once per item
    assign thr_prod    = 23'(i_cfg.detect_frac) * 23'(i_cfg.window_len);
    assign margin_prod = 23'(i_cfg.margin_frac) * 23'(i_cfg.window_len);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_thr    <= thr_prod[Q15_SHIFT +: 8];
            r_margin <= margin_prod[Q15_SHIFT +: 8];
        end
    end

    // Decision on full 12-bit accumulator values
    assign gmax       = (i_guard_a > i_guard_b) ? i_guard_a : i_guard_b;
    assign guard_need = {gmax[11], gmax} + $signed({5'b0, r_margin});
    assign det        = (i_best >= $signed({4'b0, r_thr}))
                      && ($signed({i_best[11], i_best}) >= guard_need);

    // Saturated report values, zero while warming
    always_comb begin
        o_status     = ST_WARM;
        o_band_peak  = '0;
        o_guard_peak = '0;
        if (i_warm) begin
            o_status = det ? ST_DET : ST_NODET;
            if (i_best > 12'sd1023) begin
                o_band_peak = 10'd1023;
            end else begin
                o_band_peak = i_best[9:0];
            end
            if (gmax > 12'sd1023) begin
                o_guard_peak = 11'sd1023;
            end else if (gmax < -12'sd1024) begin
                o_guard_peak = -11'sd1024;
            end else begin
                o_guard_peak = gmax[10:0];
            end
        end
    end

endmodule

// ===== hw/rtl/clipped_autocorrelation_cadence_detector.sv =====
`timescale 1ns / 1ps

// Clipped-autocorrelation cadence detector.
// Input channel: i_valid / o_stall with i_sample; a sample request is taken
// at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with o_status, o_clip_level, o_band_peak, o_guard_peak;
// one result per sample, held steady while i_stall is high.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
// the register, i_cfg_data carries the value; write only while idle.
// Timing: once warm, every band lag and both guard lags need two reads of the
// single-read-port sign ring memory, which limits the sample rate; the number
// of band lags tracked is at most MAX_BAND_LAGS. While warming the lag
// reads are skipped and a sample goes from S_WR straight to S_DEC. One
// sample is worked on at a time; the next is accepted as soon as the result
// is registered, even if the receiver still stalls it. A result that cannot
// be registered because the previous one is still stalled holds the engine.
// Reset: synchronous, active low; afterwards a clearing pass over every ring
// address zeroes the sign ring and the band accumulators, during which o_stall
// stays high (configuration writes are still taken).
module clipped_autocorrelation_cadence_detector #(
    parameter int MAX_BAND_LAGS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [1:0]  o_clip_level,
    output logic [9:0]         o_band_peak,
    output logic signed [10:0] o_guard_peak,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);
    import cacd_pkg::*;

    localparam int BIDX_W = $clog2(MAX_BAND_LAGS);
    localparam int JW     = $clog2(MAX_BAND_LAGS + 2);
    localparam logic [8:0] MAX9 = 9'(MAX_BAND_LAGS);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WR    = 3'd2;
    localparam logic [2:0] S_LAG   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;

    // control state
    logic [2:0]         r_state;
    logic [RING_AW-1:0] r_clr;
    t_cfg               r_cfg;
    t_sign              r_clip;
    logic [RING_AW-1:0] r_wpos;
    logic [8:0]         r_fill;
    logic               r_warm;
    logic [JW-1:0]      r_nband;
    logic [JW-1:0]      r_j;
    logic               r_phase;
    logic               r_p_vld;
    logic               r_p_far;
    logic [JW-1:0]      r_p_idx;
    t_acc               r_best;
    t_acc               r_guard_a;
    t_acc               r_guard_b;
    logic               r_o_valid;

    // payload
    t_sign              r_s_out;
    t_sign              r_near;
    logic [1:0]         r_o_status;
    t_sign              r_o_clip;
    logic [9:0]         r_o_band;
    logic signed [10:0] r_o_guard;

    logic               accept;
    logic               out_load;
    t_sign              clip_next;
    logic [8:0]         fill_next;
    logic [9:0]         warm_need;
    logic [8:0]         span;
    logic [7:0]         lag_sel;
    logic [JW-1:0]      j_last;

    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    t_sign              ring_wdata;
    logic [RING_AW-1:0] ring_raddr;
    logic [1:0]         ring_rdata;

    logic               band_we;
    logic [BIDX_W-1:0]  band_waddr;
    t_acc               band_wdata;
    logic [BIDX_W-1:0]  band_raddr;
    logic [11:0]        band_rdata;

    logic signed [2:0]  p_delta;
    t_acc               p_old;
    t_acc               p_new;
    logic               p_band;
    logic               p_ga;

    logic [1:0]         d_status;
    logic [9:0]         d_band;
    logic signed [10:0] d_guard;

    function automatic logic signed [2:0] sgn_mul(t_sign a, t_sign b);
        logic signed [2:0] res;
        if (a == 2'sd0 || b == 2'sd0) begin
            res = 3'sd0;
        end else if (a[1] ^ b[1]) begin
            res = -3'sd1;
        end else begin
            res = 3'sd1;
        end
        return res;
    endfunction

    assign accept      = (r_state == S_IDLE) && i_valid;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DEC) && (!r_o_valid || !i_stall);

    // Schmitt clip with hold inside the deadband
    always_comb begin
        clip_next = r_clip;
        if (i_sample >= CLIP_HIGH) begin
            clip_next = 2'sd1;
        end else if (i_sample <= CLIP_LOW) begin
            clip_next = -2'sd1;
        end
    end

    // warm-up and band size
    assign fill_next = (r_fill < 9'(RING_DEPTH)) ? r_fill + 9'd1 : r_fill;
    assign warm_need = 10'(r_cfg.window_len) + 10'(r_cfg.lag_max) + 10'd1;
    assign span      = (r_cfg.lag_max >= r_cfg.lag_min)
                     ? 9'(r_cfg.lag_max) - 9'(r_cfg.lag_min) + 9'd1 : 9'd0;
    assign j_last    = r_nband + JW'(1);

    // lag of the current issue slot: band lags, then guard a, then guard b
    always_comb begin
        if (r_j < r_nband) begin
            lag_sel = r_cfg.lag_min + 8'(r_j);
        end else if (r_j == r_nband) begin
            lag_sel = r_cfg.guard_lag_a;
        end else begin
            lag_sel = r_cfg.guard_lag_b;
        end
    end

    // ring memory port control
    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = r_wpos;
        ring_wdata = r_clip;
        if (r_state == S_CLR) begin
            ring_we    = 1'b1;
            ring_waddr = r_clr;
            ring_wdata = 2'sd0;
        end else if (r_state == S_WR) begin
            ring_we = 1'b1;
        end
        if (r_state == S_LAG) begin
            ring_raddr = r_phase ? (r_wpos - r_cfg.window_len - lag_sel)
                                 : (r_wpos - lag_sel);
        end else begin
            ring_raddr = r_wpos - r_cfg.window_len;
        end
    end

    cacd_ram #(
        .WIDTH(2),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(ring_waddr),
        .i_wdata(ring_wdata),
        .i_raddr(ring_raddr),
        .o_rdata(ring_rdata)
    );

    // returning lag: far tap and accumulator arrive together
    always_comb begin
        p_band  = (r_p_idx < r_nband);
        p_ga    = (r_p_idx == r_nband);
        p_delta = sgn_mul(r_clip, r_near) - sgn_mul(r_s_out, ring_rdata);
        if (p_band) begin
            p_old = band_rdata;
        end else if (p_ga) begin
            p_old = r_guard_a;
        end else begin
            p_old = r_guard_b;
        end
        p_new = p_old + {{9{p_delta[2]}}, p_delta};
    end

    // band accumulator memory port control
    always_comb begin
        band_we    = 1'b0;
        band_waddr = r_p_idx[BIDX_W-1:0];
        band_wdata = p_new;
        if (r_state == S_CLR) begin
            band_we    = ({1'b0, r_clr} < MAX9);
            band_waddr = r_clr[BIDX_W-1:0];
            band_wdata = '0;
        end else if (r_p_vld && r_p_far && p_band) begin
            band_we = 1'b1;
        end
    end

    assign band_raddr = r_j[BIDX_W-1:0];

    cacd_ram #(
        .WIDTH(12),
        .DEPTH(MAX_BAND_LAGS)
    ) u_band (
        .i_clk  (i_clk),
        .i_we   (band_we),
        .i_waddr(band_waddr),
        .i_wdata(band_wdata),
        .i_raddr(band_raddr),
        .o_rdata(band_rdata)
    );

    cacd_decide u_decide (
        .i_clk       (i_clk),
        .i_load      (r_state == S_WR),
        .i_cfg       (r_cfg),
        .i_warm      (r_warm),
        .i_best      (r_best),
        .i_guard_a   (r_guard_a),
        .i_guard_b   (r_guard_b),
        .o_status    (d_status),
        .o_band_peak (d_band),
        .o_guard_peak(d_guard)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lag_min     <= 8'd17;
            r_cfg.lag_max     <= 8'd25;
            r_cfg.guard_lag_a <= 8'd15;
            r_cfg.guard_lag_b <= 8'd31;
            r_cfg.window_len  <= 8'd50;
            r_cfg.detect_frac <= 15'd8192;
            r_cfg.margin_frac <= 15'd1638;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LAG_MIN:     r_cfg.lag_min     <= i_cfg_data[7:0];
                REG_LAG_MAX:     r_cfg.lag_max     <= i_cfg_data[7:0];
                REG_GUARD_A:     r_cfg.guard_lag_a <= i_cfg_data[7:0];
                REG_GUARD_B:     r_cfg.guard_lag_b <= i_cfg_data[7:0];
                REG_WINDOW_LEN:  r_cfg.window_len  <= i_cfg_data[7:0];
                REG_DETECT_FRAC: r_cfg.detect_frac <= i_cfg_data;
                REG_MARGIN_FRAC: r_cfg.margin_frac <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clip    <= 2'sd0;
            r_wpos    <= '0;
            r_fill    <= '0;
            r_warm    <= 1'b0;
            r_nband   <= '0;
            r_j       <= '0;
            r_phase   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_p_far   <= 1'b0;
            r_p_idx   <= '0;
            r_best    <= '0;
            r_guard_a <= '0;
            r_guard_b <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // return stage bookkeeping
            r_p_vld <= (r_state == S_LAG);
            r_p_far <= r_phase;
            r_p_idx <= r_j;
            if (r_p_vld && r_p_far) begin
                if (p_band) begin
                    if (p_new > r_best) begin
                        r_best <= p_new;
                    end
                end else if (p_ga) begin
                    r_guard_a <= p_new;
                end else begin
                    r_guard_b <= p_new;
                end
            end

            // output register
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == RING_AW'(RING_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_clip  <= clip_next;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_fill  <= fill_next;
                    r_warm  <= ({1'b0, fill_next} >= warm_need);
                    r_nband <= (span > MAX9) ? JW'(MAX_BAND_LAGS) : JW'(span);
                    r_best  <= '0;
                    r_j     <= '0;
                    r_phase <= 1'b0;
                    r_state <= ({1'b0, fill_next} >= warm_need) ? S_LAG : S_DEC;
                end
                S_LAG: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        r_j <= r_j + JW'(1);
                        if (r_j == j_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (out_load) begin
                        r_wpos  <= r_wpos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_s_out <= ring_rdata;
        end
        if (r_p_vld && !r_p_far) begin
            r_near <= ring_rdata;
        end
        if (out_load) begin
            r_o_status <= d_status;
            r_o_clip   <= r_clip;
            r_o_band   <= d_band;
            r_o_guard  <= d_guard;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_clip_level = r_o_clip;
    assign o_band_peak  = r_o_band;
    assign o_guard_peak = r_o_guard;

endmodule

// ===== bench/cacd_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels of the cadence
// detector, keeps its own copy of the clipper, sign ring and lag accumulators,
// and compares every result request with the oldest prediction.
module cacd_checker #(
    parameter int MAX_BAND_LAGS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_sample_valid,
    input  logic               i_sample_stall,
    input  logic signed [15:0] i_sample,
    // result channel
    input  logic               i_result_valid,
    input  logic               i_result_stall,
    input  logic [1:0]         i_status,
    input  logic signed [1:0]  i_clip_level,
    input  logic [9:0]         i_band_peak,
    input  logic signed [10:0] i_guard_peak,
    // configuration channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    // to the testbench top
    output int                 o_error_count,
    output int                 o_pending
);

    import cacd_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [1:0]  clip_level;
        logic [9:0]         band_peak;
        logic signed [10:0] guard_peak;
    } t_cadence_result;

    // Predicted detector state
    t_cfg   setting;
    t_sign  clip_hold;
    t_sign  sign_ring [RING_DEPTH];
    logic [7:0] write_pos;
    int     fill_count;
    t_acc   band_corr [MAX_BAND_LAGS];
    t_acc   guard_corr_a;
    t_acc   guard_corr_b;

    t_cadence_result cadence_result_q [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: cadence check: %s", $time, msg);
        o_error_count++;
    endtask

    task automatic clear_detector_state();
        setting.lag_min     = 8'd17;
        setting.lag_max     = 8'd25;
        setting.guard_lag_a = 8'd15;
        setting.guard_lag_b = 8'd31;
        setting.window_len  = 8'd50;
        setting.detect_frac = 15'd8192;
        setting.margin_frac = 15'd1638;
        clip_hold    = '0;
        write_pos    = '0;
        fill_count   = 0;
        guard_corr_a = '0;
        guard_corr_b = '0;
        foreach (sign_ring[k]) sign_ring[k] = '0;
        foreach (band_corr[k]) band_corr[k] = '0;
        cadence_result_q.delete();
        o_error_count = 0;
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [14:0] data);
        case (idx)
            REG_LAG_MIN:     setting.lag_min     = data[7:0];
            REG_LAG_MAX:     setting.lag_max     = data[7:0];
            REG_GUARD_A:     setting.guard_lag_a = data[7:0];
            REG_GUARD_B:     setting.guard_lag_b = data[7:0];
            REG_WINDOW_LEN:  setting.window_len  = data[7:0];
            REG_DETECT_FRAC: setting.detect_frac = data;
            REG_MARGIN_FRAC: setting.margin_frac = data;
            default: ;
        endcase
    endtask

    // Change of one lag's window sum: entering product minus leaving product.
    // Ring offsets wrap by 8-bit truncation; the new sign is already stored.
    function automatic int lag_delta(input logic [7:0] pos, input int lag, input t_sign s_out);
        logic [7:0] near_idx;
        logic [7:0] far_idx;
        near_idx = pos - 8'(lag);
        far_idx  = pos - 8'(lag + int'(setting.window_len));
        return int'(clip_hold) * int'(sign_ring[near_idx])
             - int'(s_out) * int'(sign_ring[far_idx]);
    endfunction

    task automatic predict_cadence_step(input logic signed [15:0] x,
                                        output t_cadence_result r);
        logic [7:0] pos;
        logic [7:0] out_idx;
        t_sign      s_out;
        int         n_lags;
        int         best;
        int         gmax;
        int         thr;
        int         margin;
        int         gclip;
        // Schmitt clip, level held inside the deadband
        if (x >= CLIP_HIGH) begin
            clip_hold = 2'sd1;
        end else if (x <= CLIP_LOW) begin
            clip_hold = -2'sd1;
        end

        // leaving sign is read before the new one goes in
        pos     = write_pos;
        out_idx = pos - setting.window_len;
        s_out   = sign_ring[out_idx];
        sign_ring[pos] = clip_hold;
        write_pos = pos + 8'd1;
        if (fill_count < RING_DEPTH) fill_count++;

        best = 0;
        gmax = 0;
        r.status = ST_WARM;
        if (fill_count >= int'(setting.window_len) + int'(setting.lag_max) + 1) begin
            n_lags = 0;
            if (setting.lag_max >= setting.lag_min) begin
                n_lags = int'(setting.lag_max) - int'(setting.lag_min) + 1;
            end
            if (n_lags > MAX_BAND_LAGS) n_lags = MAX_BAND_LAGS;

            // 12-bit wrapping accumulators
            for (int i = 0; i < n_lags; i++) begin
                band_corr[i] = t_acc'(int'(band_corr[i])
                             + lag_delta(pos, int'(setting.lag_min) + i, s_out));
            end
            guard_corr_a = t_acc'(int'(guard_corr_a)
                         + lag_delta(pos, int'(setting.guard_lag_a), s_out));
            guard_corr_b = t_acc'(int'(guard_corr_b)
                         + lag_delta(pos, int'(setting.guard_lag_b), s_out));

            for (int i = 0; i < n_lags; i++) begin
                if (int'(band_corr[i]) > best) best = int'(band_corr[i]);
            end
            gmax = (guard_corr_a > guard_corr_b) ? int'(guard_corr_a) : int'(guard_corr_b);

            // thresholds are Q15 fractions of the window length
            thr    = (int'(setting.detect_frac) * int'(setting.window_len)) >>> Q15_SHIFT;
            margin = (int'(setting.margin_frac) * int'(setting.window_len)) >>> Q15_SHIFT;
            r.status = (best >= thr && best >= gmax + margin) ? ST_DET : ST_NODET;
        end

        // reported peaks saturate, decisions above used full values
        gclip = (gmax > 1023) ? 1023 : ((gmax < -1024) ? -1024 : gmax);
        r.band_peak  = (best > 1023) ? 10'd1023 : 10'(best);
        r.guard_peak = 11'(gclip);
        r.clip_level = clip_hold;
    endtask

    // Result compare first, then new predictions for this edge
    always @(posedge i_clk) begin : channel_watch
        t_cadence_result want;
        if (!i_rst_n) begin
            clear_detector_state();
        end else begin
            if (i_result_valid && !i_result_stall) begin
                if (cadence_result_q.size() == 0) begin
                    report_mismatch($sformatf("result request with none expected (status %0d)",
                                              i_status));
                end else begin
                    want = cadence_result_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  i_status, want.status));
                    if (i_clip_level !== want.clip_level)
                        report_mismatch($sformatf("clip_level got %0d expected %0d",
                                                  i_clip_level, want.clip_level));
                    if (i_band_peak !== want.band_peak)
                        report_mismatch($sformatf("band_peak got %0d expected %0d",
                                                  i_band_peak, want.band_peak));
                    if (i_guard_peak !== want.guard_peak)
                        report_mismatch($sformatf("guard_peak got %0d expected %0d",
                                                  i_guard_peak, want.guard_peak));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_sample_valid && !i_sample_stall) begin
                predict_cadence_step(i_sample, want);
                cadence_result_q.push_back(want);
            end
        end
        o_pending = cadence_result_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Drives samples and register writes into the cadence detector, with random
// gaps and result backpressure; the checker beside the block does the compare.
module tb_top;

    import cacd_pkg::*;

    localparam int BAND_LAGS      = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_PHASES  = 10;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic signed [15:0] i_sample    = '0;
    logic               i_stall     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = REG_LAG_MIN;
    logic [14:0]        i_cfg_data  = '0;

    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [1:0]  o_clip_level;
    logic [9:0]         o_band_peak;
    logic signed [10:0] o_guard_peak;
    logic               o_cfg_ready;

    int error_count;
    int pending;
    int idle_cycles = 0;
    bit calm = 1'b0;    // phase with no gaps and, once a running stall ends, no backpressure

    clipped_autocorrelation_cadence_detector #(
        .MAX_BAND_LAGS(BAND_LAGS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_clip_level (o_clip_level),
        .o_band_peak  (o_band_peak),
        .o_guard_peak (o_guard_peak),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    cacd_checker #(
        .MAX_BAND_LAGS(BAND_LAGS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_valid),
        .i_sample_stall (o_stall),
        .i_sample       (i_sample),
        .i_result_valid (o_valid),
        .i_result_stall (i_stall),
        .i_status       (o_status),
        .i_clip_level   (o_clip_level),
        .i_band_peak    (o_band_peak),
        .i_guard_peak   (o_guard_peak),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result backpressure: bursts of stall and release, a few long stalls
    always @(negedge i_clk) begin : result_backpressure
        int stall_left;
        int roll;
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                i_stall    <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else if (roll < 93) begin
                i_stall    <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_stall    <= 1'b1;
                stall_left = $urandom_range(20, 120);
            end
        end
    end

    // Watchdog: too long without any request on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Mostly a square-wave cadence of the given period with random amplitude,
    // the rest deadband values, threshold edges and full-range noise.
    function automatic logic signed [15:0] cadence_sample(input int tick, input int period);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            if ((tick % period) < (period + 1) / 2) return 16'($urandom_range(100, 32767));
            v = $urandom_range(100, 32768);
            return 16'(-v);
        end
        if (roll < 82) begin
            v = $urandom_range(0, 198);
            return 16'(v - 99);
        end
        if (roll < 88) begin
            v = $urandom_range(0, 5);
            case (v)
                0: return 16'sd99;
                1: return 16'sd100;
                2: return 16'sd101;
                3: return -16'sd99;
                4: return -16'sd100;
                default: return -16'sd101;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Sample request; entered and left at a falling edge, valid left high
    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 15'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come back, then writes all registers
    task automatic apply_setting(input int lmin, input int lmax, input int ga, input int gb,
                                 input int win, input int det, input int mar);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        write_reg(REG_LAG_MIN, lmin);
        write_reg(REG_LAG_MAX, lmax);
        write_reg(REG_GUARD_A, ga);
        write_reg(REG_GUARD_B, gb);
        write_reg(REG_WINDOW_LEN, win);
        write_reg(REG_DETECT_FRAC, det);
        write_reg(REG_MARGIN_FRAC, mar);
        i_cfg_valid <= 1'b0;
        calm = ($urandom_range(0, 3) == 0);
    endtask

    // Cadence period drawn from the searched band when there is one
    task automatic run_phase(input int lmin, input int lmax, input int ga, input int gb,
                             input int win, input int det, input int mar, input int count);
        int period;
        int hi_lag;
        apply_setting(lmin, lmax, ga, gb, win, det, mar);
        if (lmax >= lmin) begin
            hi_lag = (lmax > lmin + BAND_LAGS - 1) ? lmin + BAND_LAGS - 1 : lmax;
            period = $urandom_range(lmin, hi_lag);
        end else begin
            period = $urandom_range(2, 200);
        end
        for (int k = 0; k < count; k++) begin
            send_sample(cadence_sample(k, period));
        end
        i_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int directed_samples [$] = '{0, 32767, -32768, 99, 100, 101, 50, -99, -100, -101,
                                     -50, 0, 21845, -21846, 1, -1, 100, 99, 0, -100,
                                     -99, 0, 32767, -32768, 12345};
        int lmin;
        int lmax;
        int span;
        int win;
        int det;
        int mar;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, then threshold edges and hold behavior while warming
        apply_setting(17, 25, 15, 31, 50, 8192, 1638);
        foreach (directed_samples[k]) send_sample(16'(directed_samples[k]));
        i_valid <= 1'b0;

        // defaults until warm
        run_phase(17, 25, 15, 31, 50, 8192, 1638, 90);
        // smallest window, zero threshold and margin
        run_phase(2, 2, 3, 200, 4, 0, 0, 50);
        // window that still fits with lag 2, full-scale fractions
        run_phase(2, 2, 200, 3, 252, 32767, 32767, 50);
        // window plus lag beyond the ring: stays warming
        run_phase(2, 10, 3, 4, 252, 8192, 1638, 40);
        // empty band
        run_phase(30, 20, 15, 31, 50, 8192, 1638, 50);
        // band wider than the tracked lag count, guards inside it
        run_phase(2, 200, 2, 200, 4, 4096, 1638, 50);
        // equal guards inside a full band
        run_phase(10, 73, 20, 20, 60, 8192, 0, 50);
        // top lags, ring exactly full
        run_phase(200, 200, 199, 2, 55, 0, 32767, 50);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            lmin = $urandom_range(2, 200);
            if ($urandom_range(0, 99) < 85) begin
                lmax = lmin + $urandom_range(0, (200 - lmin < 63) ? 200 - lmin : 63);
            end else begin
                lmax = $urandom_range(2, 200);
            end
            span = 255 - lmax;
            if (span > 252) span = 252;
            win = ($urandom_range(0, 99) < 85) ? $urandom_range(4, span)
                                               : $urandom_range(4, 252);
            det = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 16384)
                                               : $urandom_range(0, 32767);
            mar = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 8192)
                                               : $urandom_range(0, 32767);
            run_phase(lmin, lmax, $urandom_range(2, 200), $urandom_range(2, 200),
                      win, det, mar, $urandom_range(40, 70));
        end

        // drain and verdict
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== clipped_autocorrelation_cadence_detector.f =====
hw/rtl/cacd_pkg.sv
hw/rtl/cacd_ram.sv
hw/rtl/cacd_decide.sv
hw/rtl/clipped_autocorrelation_cadence_detector.sv
bench/cacd_checker.sv
bench/tb_top.sv
